// ===== rtl/core/cls_pkg.sv =====
// cue list section parser: shared types, field offsets and status codes
// used by cls_front, cls_queue and the top level cue_list_section_parser
// no dependencies
package cls_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_section;
  } cls_in_t;

  typedef struct packed {
    logic [31:0] cue_number;
    logic [31:0] time_ms;
    logic        has_color;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  status;
  } cls_out_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_TRUNC = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;

  // section header layout
  localparam logic [4:0] HDR_TYPE_POS  = 5'd12;
  localparam logic [4:0] HDR_COUNT_POS = 5'd16;
  localparam logic [4:0] HDR_LAST_POS  = 5'd19;
  localparam logic [4:0] HDR_LEN       = 5'd20;

  // entry layout
  localparam logic [31:0] ENT_LEN_POS  = 32'd8;
  localparam logic [31:0] ENT_CUE_POS  = 32'd12;
  localparam logic [31:0] ENT_TIME_POS = 32'd20;
  localparam logic [31:0] ENT_CLEN_POS = 32'd40;
  localparam logic [31:0] FIXED_LEN    = 32'd44;

  localparam logic [31:0] HOT_LIST      = 32'd1;
  localparam logic [31:0] LIST_TYPE_RST = 32'd1;

  localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/core/cls_front.sv =====
// cue list section parser front end: header and entry byte walker
// turns each accepted byte into zero or one result for the queue
// depends on cls_pkg
module cls_front
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  cls_in_t     in_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        res_valid,
  output cls_out_t    res_data
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_ENTRY  = 2'd1;
  localparam logic [1:0] PH_IGNORE = 2'd2;

  // color bytes sit at entry offsets 45..47 past the comment
  localparam logic [33:0] COLOR_FIRST = 34'd45;
  localparam logic [33:0] COLOR_LAST  = 34'd47;

  logic [31:0] list_type_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  hpos_r, hpos_nxt;
  logic [31:0] stype_r, stype_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] epos_r, epos_nxt;
  logic [31:0] elen_r, elen_nxt;
  logic [31:0] ecue_r, ecue_nxt;
  logic [31:0] etime_r, etime_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [23:0] color_r, color_nxt;
  logic        cseen_r, cseen_nxt;

  logic [32:0] np;
  logic [33:0] cdiff;
  logic [15:0] left_dec;
  logic [7:0]  b;
  logic        last;
  logic        keep;
  cls_out_t    ent;

  assign b        = in_data.data_byte;
  assign last     = in_data.end_of_section;
  assign np       = {1'b0, epos_r} + 33'd1;
  assign cdiff    = {2'b00, epos_r} - {2'b00, clen_r};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    stype_nxt = stype_r;
    left_nxt  = left_r;
    epos_nxt  = epos_r;
    elen_nxt  = elen_r;
    ecue_nxt  = ecue_r;
    etime_nxt = etime_r;
    clen_nxt  = clen_r;
    color_nxt = color_r;
    cseen_nxt = cseen_r;
    res_valid = 1'b0;
    res_data  = '0;
    ent       = '0;
    keep      = 1'b0;

    if (in_fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (hpos_r >= HDR_TYPE_POS && hpos_r < HDR_COUNT_POS) begin
            stype_nxt = {stype_r[23:0], b};
          end else if (hpos_r == HDR_COUNT_POS || hpos_r == HDR_COUNT_POS + 5'd1) begin
            left_nxt = {left_r[7:0], b};
          end
          if (hpos_r >= HDR_LAST_POS) begin
            hpos_nxt = HDR_LEN;
            if (stype_nxt != list_type_r || left_nxt == 16'd0) begin
              phase_nxt = PH_IGNORE;
            end else begin
              phase_nxt = PH_ENTRY;
              if (last) begin
                res_valid       = 1'b1;
                res_data.status = STAT_TRUNC;
              end
            end
          end else begin
            hpos_nxt = hpos_r + 5'd1;
          end
        end
        PH_ENTRY: begin
          if (epos_r >= ENT_LEN_POS && epos_r < ENT_CUE_POS) begin
            elen_nxt = {elen_r[23:0], b};
          end else if (epos_r >= ENT_CUE_POS && epos_r < ENT_CUE_POS + 32'd4) begin
            ecue_nxt = {ecue_r[23:0], b};
          end else if (epos_r >= ENT_TIME_POS && epos_r < ENT_TIME_POS + 32'd4) begin
            etime_nxt = {etime_r[23:0], b};
          end else if (epos_r >= ENT_CLEN_POS && epos_r < FIXED_LEN) begin
            clen_nxt = {clen_r[23:0], b};
          end else if (epos_r >= FIXED_LEN && !cdiff[33] &&
                       cdiff >= COLOR_FIRST && cdiff <= COLOR_LAST) begin
            color_nxt = {color_r[15:0], b};
            if (cdiff == COLOR_LAST) begin
              cseen_nxt = 1'b1;
            end
          end
          epos_nxt = np[31:0];

          // entry as it stands with this byte, taken before any clearing below
          ent.cue_number = ecue_nxt;
          ent.time_ms    = etime_nxt;
          ent.has_color  = cseen_nxt;
          ent.red        = cseen_nxt ? color_nxt[23:16] : 8'd0;
          ent.green      = cseen_nxt ? color_nxt[15:8]  : 8'd0;
          ent.blue       = cseen_nxt ? color_nxt[7:0]   : 8'd0;
          ent.status     = STAT_OK;
          keep           = !(list_type_r == HOT_LIST && ecue_nxt == 32'd0);

          if (np == {1'b0, FIXED_LEN} && elen_nxt < FIXED_LEN) begin
            res_valid       = 1'b1;
            res_data.status = STAT_SHORT;
            phase_nxt       = PH_IGNORE;
          end else if (np >= {1'b0, FIXED_LEN} && np == {1'b0, elen_nxt}) begin
            left_nxt = left_dec;
            if (last && left_dec != 16'd0) begin
              res_valid       = 1'b1;
              res_data.status = STAT_TRUNC;
            end else if (keep) begin
              res_valid = 1'b1;
              res_data  = ent;
            end
            epos_nxt  = '0;
            elen_nxt  = '0;
            ecue_nxt  = '0;
            etime_nxt = '0;
            clen_nxt  = '0;
            color_nxt = '0;
            cseen_nxt = 1'b0;
            if (left_dec == 16'd0) begin
              phase_nxt = PH_IGNORE;
            end
          end else if (last) begin
            if (np < {1'b0, FIXED_LEN} || left_r > 16'd1) begin
              res_valid       = 1'b1;
              res_data.status = STAT_TRUNC;
            end else if (keep) begin
              res_valid = 1'b1;
              res_data  = ent;
            end
          end
        end
        default: begin
        end
      endcase

      // end of section resets everything but the list type
      if (last) begin
        phase_nxt = PH_HEADER;
        hpos_nxt  = '0;
        stype_nxt = '0;
        left_nxt  = '0;
        epos_nxt  = '0;
        elen_nxt  = '0;
        ecue_nxt  = '0;
        etime_nxt = '0;
        clen_nxt  = '0;
        color_nxt = '0;
        cseen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_type_r <= LIST_TYPE_RST;
      phase_r     <= PH_HEADER;
      hpos_r      <= '0;
      stype_r     <= '0;
      left_r      <= '0;
      epos_r      <= '0;
      elen_r      <= '0;
      ecue_r      <= '0;
      etime_r     <= '0;
      clen_r      <= '0;
      color_r     <= '0;
      cseen_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        list_type_r <= cfg_wdata;
      end
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      stype_r <= stype_nxt;
      left_r  <= left_nxt;
      epos_r  <= epos_nxt;
      elen_r  <= elen_nxt;
      ecue_r  <= ecue_nxt;
      etime_r <= etime_nxt;
      clen_r  <= clen_nxt;
      color_r <= color_nxt;
      cseen_r <= cseen_nxt;
    end
  end

endmodule

// ===== rtl/core/cls_queue.sv =====
// cue list section parser back end: result queue feeding the output channel
// decouples the byte walker from output back-pressure
// depends on cls_pkg
module cls_queue
  import cls_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cls_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_ready,
  output cls_out_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cls_out_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign full      = (count_r == CNT_FULL);
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/cue_list_section_parser.sv =====
// cue list section parser top level: byte walker front end plus result queue
// depends on cls_pkg, cls_front, cls_queue
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | cls_in_t  (data byte, end of section)
//   out_    | output    | out_valid / out_ready | cls_out_t (one decoded cue or status)
//   cfg_    | input     | cfg_we                | 32-bit expected list type
//
// one byte per cycle while in_ready is high; a byte's result, if any, is queued in the same cycle
// and shows on out_ once the results queued ahead of it have been taken
// in_ready drops only while the DEPTH-entry result queue is full
// synchronous active-low reset; list type resets to the hot list
module cue_list_section_parser
  import cls_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cls_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cls_out_t    out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic     in_fire;
  logic     res_valid;
  cls_out_t res_data;
  logic     q_full;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  cls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  cls_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/cls_tb_pkg.sv =====
// cue list section parser testbench: cue predictor and result checker class
// depends on cls_pkg for the beat and result structs, offsets and status codes
package cls_tb_pkg;
  import cls_pkg::*;

  typedef enum logic [1:0] {WALK_HEADER, WALK_ENTRY, WALK_SKIP} walk_phase_t;

  class cue_tracker;
    logic [31:0] list_type;
    walk_phase_t phase;
    int unsigned hdr_pos;
    logic [31:0] sect_type;
    logic [15:0] cues_left;
    logic [31:0] ent_pos;
    logic [31:0] ent_len;
    logic [31:0] ent_cue;
    logic [31:0] ent_time;
    logic [31:0] note_len;
    logic [23:0] rgb;
    bit          rgb_full;
    cls_out_t    pending[$];
    int unsigned emitted;
    int unsigned checked;
    int unsigned faults;

    function new();
      list_type = LIST_TYPE_RST;
      emitted = 0;
      checked = 0;
      faults = 0;
      clear_section();
    endfunction

    function void clear_entry();
      ent_pos = '0;
      ent_len = '0;
      ent_cue = '0;
      ent_time = '0;
      note_len = '0;
      rgb = '0;
      rgb_full = 0;
    endfunction

    function void clear_section();
      phase = WALK_HEADER;
      hdr_pos = 0;
      sect_type = '0;
      cues_left = '0;
      clear_entry();
    endfunction

    // zero cue numbers vanish in a hot list
    function bit entry_result(output cls_out_t r);
      r = '0;
      if (list_type == HOT_LIST && ent_cue == '0) return 0;
      r.cue_number = ent_cue;
      r.time_ms = ent_time;
      r.has_color = rgb_full;
      if (rgb_full) {r.red, r.green, r.blue} = rgb;
      r.status = STAT_OK;
      return 1;
    endfunction

    function void predict_cues(cls_in_t beat);
      logic [7:0] b;
      bit last;
      bit emit;
      longint unsigned p;
      longint unsigned np;
      longint unsigned cstart;
      cls_out_t res;
      b = beat.data_byte;
      last = beat.end_of_section;
      emit = 0;
      res = '0;
      case (phase)
        WALK_HEADER: begin
          if (hdr_pos >= HDR_TYPE_POS && hdr_pos < HDR_COUNT_POS)
            sect_type = {sect_type[23:0], b};
          else if (hdr_pos == HDR_COUNT_POS || hdr_pos == HDR_COUNT_POS + 1)
            cues_left = {cues_left[7:0], b};
          hdr_pos++;
          if (hdr_pos >= HDR_LEN) begin
            hdr_pos = HDR_LEN;
            if (sect_type != list_type || cues_left == '0) begin
              phase = WALK_SKIP;
            end else begin
              phase = WALK_ENTRY;
              if (last) begin
                res.status = STAT_TRUNC;
                emit = 1;
              end
            end
          end
        end
        WALK_ENTRY: begin
          p = 64'(ent_pos);
          cstart = 64'(FIXED_LEN) + 64'(note_len);
          np = p + 1;
          if (p >= ENT_LEN_POS && p < ENT_LEN_POS + 4)
            ent_len = {ent_len[23:0], b};
          else if (p >= ENT_CUE_POS && p < ENT_CUE_POS + 4)
            ent_cue = {ent_cue[23:0], b};
          else if (p >= ENT_TIME_POS && p < ENT_TIME_POS + 4)
            ent_time = {ent_time[23:0], b};
          else if (p >= ENT_CLEN_POS && p < ENT_CLEN_POS + 4)
            note_len = {note_len[23:0], b};
          else if (p >= FIXED_LEN && p >= cstart + 1 && p <= cstart + 3) begin
            // first byte of the color word is padding, then r g b
            rgb = {rgb[15:0], b};
            if (p == cstart + 3) rgb_full = 1;
          end
          ent_pos = np[31:0];
          if (np == FIXED_LEN && ent_len < FIXED_LEN) begin
            res.status = STAT_SHORT;
            emit = 1;
            phase = WALK_SKIP;
          end else if (np >= FIXED_LEN && np == ent_len) begin
            cues_left = cues_left - 16'd1;
            if (last && cues_left != '0) begin
              res.status = STAT_TRUNC;
              emit = 1;
            end else begin
              emit = entry_result(res);
            end
            clear_entry();
            if (cues_left == '0) phase = WALK_SKIP;
          end else if (last) begin
            if (np < FIXED_LEN || cues_left > 16'd1) begin
              res.status = STAT_TRUNC;
              emit = 1;
            end else begin
              emit = entry_result(res);
            end
          end
        end
        default: ;
      endcase
      if (emit) begin
        pending.insert(pending.size(), res);
        emitted++;
      end
      if (last) clear_section();
    endfunction

    function string show(cls_out_t r);
      return $sformatf("cue=%h time=%h color=%b rgb=%h_%h_%h status=%0d",
                       r.cue_number, r.time_ms, r.has_color, r.red, r.green, r.blue,
                       r.status);
    endfunction

    function void check_cue(cls_out_t got);
      cls_out_t want;
      bit bad;
      checked++;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result %0d arrived with nothing pending: %s", checked, show(got));
        return;
      end
      want = pending.pop_front();
      bad = (got.cue_number !== want.cue_number) || (got.time_ms !== want.time_ms) ||
            (got.has_color !== want.has_color) || (got.red !== want.red) ||
            (got.green !== want.green) || (got.blue !== want.blue) ||
            (got.status !== want.status);
      if (bad) begin
        faults++;
        if (faults <= 10)
          $display("result %0d differs\n  expected %s\n  got      %s", checked,
                   show(want), show(got));
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_cue_list_section_parser.sv =====
// cue list section parser testbench top: clock, reset, beat drivers, result monitor
// depends on cls_pkg, cls_tb_pkg and the cue_list_section_parser rtl
module tb_cue_list_section_parser;
  import cls_pkg::*;
  import cls_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 800;
  localparam int unsigned PHASE_BEATS = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  cls_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  cls_out_t    out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  cue_tracker  board = new();
  logic [7:0]  sect[$];
  bit          calm;
  bit          stall_req;
  int unsigned sent_beats;
  int unsigned cycles;

  cue_list_section_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_cue(out_data);
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_req = 0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  task automatic send_beat(cls_in_t beat);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.predict_cues(beat);
    sent_beats++;
  endtask

  task automatic send_section();
    cls_in_t beat;
    foreach (sect[i]) begin
      beat.data_byte = sect[i];
      beat.end_of_section = (i == sect.size() - 1);
      send_beat(beat);
    end
  endtask

  // drop valid, wait for every pending result, then a few quiet cycles
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_list_type(logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.list_type = value;
  endtask

  function automatic void add_byte(logic [7:0] v);
    sect.insert(sect.size(), v);
  endfunction

  task automatic open_section(logic [31:0] ltype, logic [15:0] count);
    sect.delete();
    repeat (HDR_TYPE_POS) add_byte(8'($urandom));
    for (int i = 3; i >= 0; i--) add_byte(ltype[8*i +: 8]);
    add_byte(count[15:8]);
    add_byte(count[7:0]);
    repeat (HDR_LEN - HDR_COUNT_POS - 2) add_byte(8'($urandom));
  endtask

  function automatic logic [7:0] entry_byte(int unsigned i, logic [31:0] len,
      logic [31:0] cue, logic [31:0] tm, logic [31:0] clen, logic [23:0] rgb);
    longint unsigned cs;
    cs = 64'(FIXED_LEN) + 64'(clen);
    if (i >= ENT_LEN_POS && i < ENT_LEN_POS + 4) return len[8*(ENT_LEN_POS + 3 - i) +: 8];
    if (i >= ENT_CUE_POS && i < ENT_CUE_POS + 4) return cue[8*(ENT_CUE_POS + 3 - i) +: 8];
    if (i >= ENT_TIME_POS && i < ENT_TIME_POS + 4) return tm[8*(ENT_TIME_POS + 3 - i) +: 8];
    if (i >= ENT_CLEN_POS && i < ENT_CLEN_POS + 4)
      return clen[8*(ENT_CLEN_POS + 3 - i) +: 8];
    if (i > cs && i <= cs + 3) return rgb[8*(cs + 3 - i) +: 8];
    return 8'($urandom);
  endfunction

  // cut < 0 pushes the whole entry, at least the fixed part
  task automatic add_entry(logic [31:0] len, logic [31:0] cue, logic [31:0] tm,
      logic [31:0] clen, logic [23:0] rgb, int cut = -1);
    int unsigned span;
    span = (cut >= 0) ? cut : ((len < FIXED_LEN) ? FIXED_LEN : len);
    for (int unsigned i = 0; i < span; i++)
      add_byte(entry_byte(i, len, cue, tm, clen, rgb));
  endtask

  // stop is set when the entry ends the useful part of the section
  task automatic add_random_entry(output bit stop);
    logic [31:0] cue;
    logic [31:0] tm;
    logic [31:0] clen;
    logic [31:0] len;
    int pick;
    int shape;
    stop = 0;
    pick = $urandom_range(99);
    cue = (pick < 15) ? 32'h0 : (pick < 25) ? 32'hFFFF_FFFF : 32'($urandom);
    pick = $urandom_range(99);
    tm = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFF_FFFF : 32'($urandom);
    clen = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(6));
    shape = $urandom_range(99);
    if (shape < 6) begin
      add_entry($urandom_range(43), cue, tm, clen, 24'($urandom));
      stop = 1;
    end else if (shape < 10) begin
      // huge length, section ends at or past the end of the fixed part
      add_entry(32'($urandom) | 32'h100, cue, tm, clen, 24'($urandom),
                FIXED_LEN + $urandom_range(40));
      stop = 1;
    end else begin
      if (clen > 6) len = FIXED_LEN + $urandom_range(8);
      else if (shape < 50) len = FIXED_LEN + clen + 4 + $urandom_range(3);
      else if (shape < 62) len = FIXED_LEN + clen + $urandom_range(1, 3);
      else len = FIXED_LEN + $urandom_range(3);
      add_entry(len, cue, tm, clen, 24'($urandom));
    end
  endtask

  task automatic random_section(logic [31:0] ltype);
    int kind;
    int count;
    bit stop;
    kind = $urandom_range(99);
    sect.delete();
    stop = 0;
    if (kind < 8) begin
      repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
    end else if (kind < 14) begin
      open_section(ltype, 16'($urandom_range(1, 3)));
      sect = sect[0:$urandom_range(18)];
    end else begin
      count = $urandom_range(1, 3);
      if (kind < 20) open_section(ltype ^ (32'd1 << $urandom_range(31)), 16'(count));
      else if (kind < 24) open_section(ltype, 16'd0);
      else if (kind < 28) open_section(ltype, 16'($urandom));
      else open_section(ltype, 16'(count));
      for (int k = 0; k < count && !stop; k++) add_random_entry(stop);
      if (!stop) begin
        if ($urandom_range(99) < 15) sect = sect[0:$urandom_range(19, sect.size() - 2)];
        else repeat ($urandom_range(3)) add_byte(8'($urandom));
      end
    end
    send_section();
  endtask

  initial begin
    logic [31:0] phase_types[4];
    int unsigned start_beats;
    int unsigned sections;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 0;
    stall_req = 0;
    sent_beats = 0;
    cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // hot list from reset
    open_section(HOT_LIST, 16'd1);
    sect = sect[0:18];
    send_section();
    open_section(HOT_LIST, 16'd1);
    send_section();
    open_section(32'h2, 16'd1);
    send_section();
    open_section(HOT_LIST, 16'd0);
    send_section();
    open_section(HOT_LIST, 16'd3);
    add_entry(52, 0, 32'h1234, 2, 24'hABCDEF);
    add_entry(48, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 24'hFFFFFF);
    add_entry(50, 1, 0, 2, 24'h000000);
    repeat (3) add_byte(8'($urandom));
    send_section();
    // color word hanging past the entry, then an entry of exactly the fixed size
    open_section(HOT_LIST, 16'd2);
    add_entry(49, 3, 4, 3, 24'($urandom));
    add_entry(44, 5, 6, 0, 24'($urandom));
    send_section();
    open_section(HOT_LIST, 16'd2);
    add_entry(43, 3, 4, 0, 24'($urandom));
    send_section();
    open_section(HOT_LIST, 16'd1);
    add_entry(60, 8, 9, 1, 24'($urandom), 30);
    send_section();
    open_section(HOT_LIST, 16'd2);
    add_entry(48, 10, 11, 0, 24'($urandom));
    send_section();
    // last owed entry cut short, with and without a full color
    open_section(HOT_LIST, 16'd1);
    add_entry(80, 12, 13, 2, 24'($urandom), 52);
    send_section();
    open_section(HOT_LIST, 16'd1);
    add_entry(80, 14, 15, 2, 24'($urandom), 48);
    send_section();
    settle();

    // not a hot list: zero cue numbers come through
    write_list_type(32'h0);
    open_section(32'h0, 16'd1);
    add_entry(52, 0, 32'hFFFF_FFFF, 4, 24'h123456);
    send_section();

    phase_types = '{32'hFFFF_FFFF, 32'h0, 32'($urandom), HOT_LIST};
    foreach (phase_types[n]) begin
      settle();
      write_list_type(phase_types[n]);
      calm = (n == 2);
      if (n == 1) begin
        stall_req = 1;
        // header-only sections with entries owed give one status each
        repeat (6) begin
          open_section(phase_types[n], 16'd1);
          send_section();
        end
      end
      start_beats = sent_beats;
      sections = 0;
      while (sent_beats - start_beats < PHASE_BEATS && sections < 20) begin
        random_section(phase_types[n]);
        sections++;
      end
    end
    calm = 0;

    settle();
    repeat (20) @(posedge clk);
    if (board.faults == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cls_pkg.sv
rtl/core/cls_front.sv
rtl/core/cls_queue.sv
rtl/core/cue_list_section_parser.sv
verif/cls_tb_pkg.sv
verif/tb_cue_list_section_parser.sv
